// ===== src/wrlm_pkg.sv =====
// ----------------------------------------------------------------------------
// wrlm_pkg - shared types and constants of the windowed RMS level meter
// Field widths, fixed-point sizes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package wrlm_pkg;

   localparam int SAMPLE_W   = 16;   // PCM sample width
   localparam int LEVEL_W    = 16;   // level output width, unsigned Q0.16
   localparam int WIN_CFG_W  = 13;   // window_length register width
   localparam int MIN_WINDOW = 64;   // smallest usable window
   localparam int SQ_W       = 31;   // a square is at most 2^30
   localparam int MEAN_W     = 31;   // the mean of squares is at most 2^30
   localparam int RAD_W      = 32;   // radicand padded to an even width
   localparam int ROOT_W     = 16;   // floor root is at most 32768
   localparam int SQRT_REM_W = 18;   // partial remainder of the root
   localparam int SCALED_W   = 19;   // root times six before saturation

   localparam logic [WIN_CFG_W-1:0] WIN_RESET = 13'd1102;
   localparam logic [LEVEL_W-1:0]   LEVEL_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQ_OLD,
      ST_SQ_NEW,
      ST_ADD,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } meter_state_type;

endpackage : wrlm_pkg

`default_nettype wire

// ===== src/windowed_rms_level_meter.sv =====
// ----------------------------------------------------------------------------
// windowed_rms_level_meter - sliding-window RMS level of a PCM sample stream
// Keeps the last window_length samples, their sum of squares and a fill
// count, and reports floor(sqrt(sum / count)) * 6 saturated to 16 bits.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per sample. req_mode 0 pushes req_sample and reports the
//            new level; req_mode 1 empties the window and reports level 0.
//   rsp_*  : one level item per request item, in order.
//   csr_*  : a write to window_length empties the window. Write only while
//            the block is idle. Values are clamped to 64..MAX_WINDOW.
// Sequence:
//   A push item runs read, old square, new square, add, a SUM_W-bit divide
//   (SUM_W = 31 + log2(MAX_WINDOW)), a 16-bit square root and done. A stop
//   item goes straight from acceptance to done. The bit-serial divider (one
//   quotient bit a cycle) and the square root (one root bit a cycle) both run
//   on the one shared subtractor. req_stall is high for the whole
//   computation, so one item is in work at a time.
// Reset: synchronous, clears the window and restores window_length to 1102.
// Stall: a finished level waits in the output register while rsp_stall is
//   high; a further finished level holds in the sequencer until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_rms_level_meter #(
   parameter int MAX_WINDOW = 4096
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic                           req_mode,
   input  wire logic signed [wrlm_pkg::SAMPLE_W-1:0] req_sample,
   // result channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic [wrlm_pkg::LEVEL_W-1:0]   rsp_level,
   // configuration
   input  wire logic                           csr_write_en,
   input  wire logic [wrlm_pkg::WIN_CFG_W-1:0] csr_write_data
);

   import wrlm_pkg::*;

   // ring slot index, fill count / window size, sum of squares
   localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW    = $clog2(MAX_WINDOW + 1);
   localparam int AW    = (CW > WIN_CFG_W) ? CW : WIN_CFG_W;
   localparam int SUM_W = SQ_W + $clog2(MAX_WINDOW);
   localparam int R_W   = (CW + 1 > SQRT_REM_W) ? CW + 1 : SQRT_REM_W;
   localparam int CNT_W = $clog2(SUM_W);

   // --------------------------------------------------------------------
   // state
   // --------------------------------------------------------------------
   meter_state_type state_ff, state_in;

   logic [WIN_CFG_W-1:0]       window_length_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [CW-1:0]              fill_ff;
   logic [SW-1:0]              slot_ff;
   logic                       rsp_valid_ff;
   logic [LEVEL_W-1:0]         level_ff;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic [SW-1:0]              old_addr_ff;
   logic                       full_ff;
   logic [SQ_W-1:0]            prod_ff;
   logic [SUM_W-1:0]           div_ff;
   logic [R_W-1:0]             rem_ff;
   logic [RAD_W-1:0]           rad_ff;
   logic [ROOT_W-1:0]          root_ff;
   logic [CNT_W-1:0]           cnt_ff;

   logic [SAMPLE_W-1:0]        ring_mem [MAX_WINDOW];

   // --------------------------------------------------------------------
   // window size and oldest slot
   // --------------------------------------------------------------------
   logic [AW-1:0]   wl_ext;
   logic [CW-1:0]   win;
   logic [CW:0]     slot_ext;
   logic [CW:0]     win_ext;
   logic [CW:0]     old_addr;
   logic            req_accept;

   always_comb begin
      wl_ext = AW'(window_length_ff);
      if (wl_ext < AW'(MIN_WINDOW)) begin
         win = CW'(MIN_WINDOW);
      end else if (wl_ext > AW'(MAX_WINDOW)) begin
         win = CW'(MAX_WINDOW);
      end else begin
         win = CW'(wl_ext);
      end
      slot_ext = (CW + 1)'(slot_ff);
      win_ext  = (CW + 1)'(win);
      // oldest sample sits window places back, wrapping around the ring
      if (slot_ext >= win_ext) begin
         old_addr = slot_ext - win_ext;
      end else begin
         old_addr = slot_ext + (CW + 1)'(MAX_WINDOW) - win_ext;
      end
   end

   assign req_accept = req_valid && !req_stall;

   // --------------------------------------------------------------------
   // shared squarer and shared subtractor
   // --------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0]   mul_op;
   logic signed [2*SAMPLE_W-1:0] mul_res;
   logic [SUM_W-1:0]             sub_a;
   logic [SUM_W-1:0]             sub_b;
   logic [SUM_W:0]               sub_diff;
   logic                         sub_borrow;
   logic [R_W-1:0]               div_shift;
   logic [R_W-1:0]               sqrt_shift;
   logic [SQRT_REM_W-1:0]        sqrt_trial;
   logic [SCALED_W-1:0]          scaled;
   logic                         rsp_load;

   // output decode: operand selection and handshake controls
   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      mul_op     = (state_ff == ST_SQ_OLD) ? rd_ff : sample_ff;
      div_shift  = {rem_ff[R_W-2:0], div_ff[SUM_W-1]};
      sqrt_shift = {rem_ff[R_W-3:0], rad_ff[RAD_W-1 -: 2]};
      sqrt_trial = {root_ff, 2'b01};
      case (state_ff)
         ST_DIV: begin
            sub_a = SUM_W'(div_shift);
            sub_b = SUM_W'(fill_ff);
         end
         ST_SQRT: begin
            sub_a = SUM_W'(sqrt_shift);
            sub_b = SUM_W'(sqrt_trial);
         end
         default: begin
            sub_a = sum_ff;
            sub_b = SUM_W'(prod_ff);
         end
      endcase
      rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   assign mul_res    = mul_op * mul_op;
   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_diff[SUM_W];
   assign scaled     = (SCALED_W'(root_ff) << 2) + (SCALED_W'(root_ff) << 1);

   // --------------------------------------------------------------------
   // sequencer next state
   // --------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = req_mode ? ST_DONE : ST_READ;
            end
         end
         ST_READ:   state_in = ST_SQ_OLD;
         ST_SQ_OLD: state_in = ST_SQ_NEW;
         ST_SQ_NEW: state_in = ST_ADD;
         ST_ADD:    state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------------
   // control registers
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         window_length_ff <= WIN_RESET;
         sum_ff           <= '0;
         fill_ff          <= '0;
         slot_ff          <= '0;
      end else begin
         state_ff <= state_in;

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_write_en) begin
            // a new window length starts an empty window
            window_length_ff <= csr_write_data;
            sum_ff           <= '0;
            fill_ff          <= '0;
            slot_ff          <= '0;
         end else begin
            case (state_ff)
               ST_IDLE: begin
                  // stop item: drop the whole window
                  if (req_accept && req_mode) begin
                     sum_ff  <= '0;
                     fill_ff <= '0;
                     slot_ff <= '0;
                  end
               end
               ST_SQ_NEW: begin
                  // retire the oldest square once the window is full
                  if (full_ff) begin
                     sum_ff <= sub_diff[SUM_W-1:0];
                  end
               end
               ST_ADD: begin
                  sum_ff <= sum_ff + SUM_W'(prod_ff);
                  if (!full_ff) begin
                     fill_ff <= fill_ff + 1'b1;
                  end
                  if ((CW + 1)'(slot_ff) + 1'b1 == (CW + 1)'(MAX_WINDOW)) begin
                     slot_ff <= '0;
                  end else begin
                     slot_ff <= slot_ff + 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // --------------------------------------------------------------------
   // datapath registers
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            sample_ff   <= req_sample;
            old_addr_ff <= old_addr[SW-1:0];
            full_ff     <= (fill_ff >= win);
            root_ff     <= '0;
         end
         ST_SQ_OLD: begin
            prod_ff <= mul_res[SQ_W-1:0];
         end
         ST_SQ_NEW: begin
            prod_ff <= mul_res[SQ_W-1:0];
         end
         ST_ADD: begin
            div_ff <= sum_ff + SUM_W'(prod_ff);
            rem_ff <= '0;
            cnt_ff <= CNT_W'(SUM_W - 1);
         end
         ST_DIV: begin
            // one restoring quotient bit per cycle
            div_ff <= {div_ff[SUM_W-2:0], !sub_borrow};
            if (cnt_ff == '0) begin
               rad_ff  <= RAD_W'({div_ff[MEAN_W-2:0], !sub_borrow});
               rem_ff  <= '0;
               root_ff <= '0;
               cnt_ff  <= CNT_W'(ROOT_W - 1);
            end else begin
               if (!sub_borrow) begin
                  rem_ff <= sub_diff[R_W-1:0];
               end else begin
                  rem_ff <= div_shift;
               end
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
         ST_SQRT: begin
            // one root bit per cycle
            if (!sub_borrow) begin
               rem_ff  <= sub_diff[R_W-1:0];
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= sqrt_shift;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
            rad_ff <= rad_ff << 2;
            cnt_ff <= cnt_ff - 1'b1;
         end
         default: begin
         end
      endcase

      if (rsp_load) begin
         if (scaled > SCALED_W'(LEVEL_MAX)) begin
            level_ff <= LEVEL_MAX;
         end else begin
            level_ff <= scaled[LEVEL_W-1:0];
         end
      end
   end

   // --------------------------------------------------------------------
   // sample ring: read the oldest entry, write the new one, same cycle
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         ring_mem[slot_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_ff <= ring_mem[old_addr_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = level_ff;

   // --------------------------------------------------------------------
   // assertions
   // --------------------------------------------------------------------
   a_fill_within_window : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (fill_ff <= win))
      else $error("fill count exceeds active window");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final step");

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_READ || state_ff == ST_DONE))
      else $error("accepted item did not start the sequence");

   a_root_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (root_ff <= ROOT_W'(32768)))
      else $error("root beyond full scale");

endmodule : windowed_rms_level_meter

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the windowed RMS level meter
// Streams signed PCM items and stop items through the meter under several
// window lengths, predicts every level from a behavioral copy of the window
// (ring, running sum of squares, fill count), and checks each level item in
// order while both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
   import wrlm_pkg::*;

   localparam int HALF_PERIOD  = 10;          // 20 ns clock
   localparam int RESET_CYCLES = 7;
   localparam int RING_DEPTH   = 4096;        // MAX_WINDOW of the meter
   localparam int DRAIN_CYCLES = 80;          // settle time after the last level is checked
   localparam int TIMEOUT_NS   = 20_000_000;  // watchdog limit for the whole run
   localparam int PRINT_LIMIT  = 20;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_STOP = 1'b1;

   typedef struct packed {
      logic                mode;
      logic [SAMPLE_W-1:0] sample;
   } meter_item_type;

   // ---------------------------------------------------------------------
   // DUT ports; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_mode = MODE_PUSH;
   logic signed [SAMPLE_W-1:0]  req_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]          rsp_level;
   logic                        csr_write_en = 1'b0;
   logic [WIN_CFG_W-1:0]        csr_write_data = '0;

   always #(HALF_PERIOD) clock = ~clock;

   windowed_rms_level_meter #(
      .MAX_WINDOW(RING_DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_level      (rsp_level),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   meter_item_type       sample_queue[$];    // items waiting for the driver
   logic [LEVEL_W-1:0]   pending_levels[$];  // predicted levels, oldest first
   int                   items_queued  = 0;
   int                   items_taken   = 0;
   int                   stops_taken   = 0;
   int                   levels_seen   = 0;
   int                   window_writes = 0;
   int                   fail_count    = 0;
   bit                   idle_on       = 1'b1;
   int                   req_gap       = 0;
   int                   stall_left    = 0;

   // Behavioral copy of the meter window
   logic [SAMPLE_W-1:0]  win_ring[RING_DEPTH];
   logic [42:0]          square_sum  = '0;
   logic [12:0]          fill_count  = '0;
   logic [11:0]          write_slot  = '0;
   logic [WIN_CFG_W-1:0] window_cfg  = WIN_RESET;

   // ---------------------------------------------------------------------
   // Level predictor
   // ---------------------------------------------------------------------
   function automatic void empty_window();
      square_sum = '0;
      fill_count = '0;
      write_slot = '0;
   endfunction

   function automatic longint unsigned square_of(input logic [SAMPLE_W-1:0] bits);
      longint s;
      s = $signed(bits);
      return s * s;
   endfunction

   // Advance the window by one item and return the level it reports.
   function automatic logic [LEVEL_W-1:0] predict_level(input logic mode,
                                                        input logic [SAMPLE_W-1:0] bits);
      int unsigned       win;
      logic [11:0]       old_slot;
      longint unsigned   mean;
      longint unsigned   root;
      longint unsigned   trial;
      longint unsigned   scaled;
      if (mode == MODE_STOP) begin
         empty_window();
         return '0;
      end
      // clamp the register to the usable window range
      win = window_cfg;
      if (win < MIN_WINDOW) win = MIN_WINDOW;
      if (win > RING_DEPTH) win = RING_DEPTH;
      if (fill_count >= win) begin
         // full window: drop the sample that falls out; 12-bit slot wraps the ring
         old_slot   = write_slot - 12'(win);
         square_sum = square_sum - 43'(square_of(win_ring[old_slot]));
      end else begin
         fill_count = fill_count + 13'd1;
      end
      win_ring[write_slot] = bits;
      square_sum = square_sum + 43'(square_of(bits));
      write_slot = write_slot + 12'd1;
      mean = longint'(square_sum) / longint'(fill_count);
      // floor square root, one bit at a time from the top
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= mean) root = trial;
      end
      scaled = root * 6;
      if (scaled > LEVEL_MAX) return LEVEL_MAX;
      return scaled[LEVEL_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Failure reporting: one line per failure, print a bounded number
   // ---------------------------------------------------------------------
   task automatic report_failure(input string msg);
      if (fail_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   // ---------------------------------------------------------------------
   // Request driver: pop the next item once the current one is taken,
   // and insert random idle bursts between items
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      meter_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            next_item  = sample_queue.pop_front();
            req_valid  <= 1'b1;
            req_mode   <= next_item.mode;
            req_sample <= next_item.sample;
            if (idle_on && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict on every accepted item
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_levels.push_back(predict_level(req_mode, req_sample));
         items_taken++;
         if (req_mode == MODE_STOP) stops_taken++;
      end
   end

   // ---------------------------------------------------------------------
   // Result side: random stall bursts, then check each taken level
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      logic [LEVEL_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         levels_seen++;
         if (pending_levels.size() == 0) begin
            report_failure($sformatf("level %0d with no item outstanding", rsp_level));
         end else begin
            want = pending_levels.pop_front();
            if (rsp_level !== want)
               report_failure($sformatf("level %0d, expected %0d (result %0d)",
                                        rsp_level, want, levels_seen));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_item(input logic mode, input logic [SAMPLE_W-1:0] bits);
      sample_queue.push_back('{mode: mode, sample: bits});
      items_queued++;
   endtask

   // Mix full-scale, quiet, mid-level and extreme samples
   function automatic logic [SAMPLE_W-1:0] random_sample();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5:       v = int'($urandom_range(0, 511)) - 256;
         6: begin
            case ($urandom_range(0, 4))
               0:       v = 32767;
               1:       v = -32768;
               2:       v = -32767;
               3:       v = 1;
               default: v = -1;
            endcase
         end
         7, 8:       v = int'($urandom_range(0, 8191)) - 4096;
         default:    v = $urandom_range(0, 15);
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   // Hold until every item is taken and every level checked, then let the
   // meter settle before touching the register
   task automatic wait_for_drain();
      while (items_taken != items_queued || pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [WIN_CFG_W-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      // any write empties the window
      window_cfg = value;
      empty_window();
      window_writes++;
   endtask

   // One window setting: drain, write the register, stream pushes with
   // occasional stop items (one in stop_one_in, none when zero)
   task automatic run_phase(input logic [WIN_CFG_W-1:0] win_value, input int count,
                            input int stop_one_in, input bit with_idle);
      logic mode;
      wait_for_drain();
      write_window(win_value);
      idle_on = with_idle;
      for (int i = 0; i < count; i++) begin
         mode = (stop_one_in != 0 && $urandom_range(1, stop_one_in) == 1) ? MODE_STOP
                                                                          : MODE_PUSH;
         queue_item(mode, random_sample());
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      for (int i = 0; i < RING_DEPTH; i++) win_ring[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset window length: stop on an empty window,
      // full-scale saturation, exact roots, back-to-back stops, small levels
      queue_item(MODE_STOP, 16'h1234);
      queue_item(MODE_PUSH, 16'h7FFF);
      queue_item(MODE_PUSH, 16'h8000);
      queue_item(MODE_PUSH, 16'h0000);
      queue_item(MODE_PUSH, 16'h0001);
      queue_item(MODE_PUSH, 16'hFFFF);
      queue_item(MODE_STOP, 16'hFFFF);
      queue_item(MODE_STOP, 16'h0000);
      queue_item(MODE_PUSH, 16'h0000);
      queue_item(MODE_PUSH, 16'h8000);
      queue_item(MODE_STOP, 16'h8000);
      queue_item(MODE_PUSH, 16'd100);
      queue_item(MODE_PUSH, 16'hFFFF);
      queue_item(MODE_PUSH, 16'd5461);
      queue_item(MODE_PUSH, -16'sd5462);
      queue_item(MODE_STOP, 16'h7FFF);
      queue_item(MODE_PUSH, 16'd10922);
      queue_item(MODE_PUSH, -16'sd10923);

      // Random part: below-range, minimum, short, above-range, maximum and
      // reset-value windows; short windows fill and slide many times
      run_phase(13'd0,    200, 100, 1'b1);
      run_phase(13'd63,    60,   0, 1'b0);
      run_phase(13'd64,   150,   0, 1'b1);
      run_phase(13'($urandom_range(65, 200)), 250, 150, 1'b1);
      run_phase(13'h1FFF, 120, 200, 1'b1);
      run_phase(13'd4096,  60,   0, 1'b1);
      run_phase(13'd4097,  30,   0, 1'b1);
      run_phase(WIN_RESET, 100, 80, 1'b1);
      // last stretch runs without any idling
      run_phase(13'($urandom_range(64, 300)), 150, 100, 1'b0);

      wait_for_drain();
      $display("Ran %0d items (%0d stops) over %0d window writes plus the reset length;",
               items_taken, stops_taken, window_writes);
      $display("checked %0d level results with %0d mismatches.", levels_seen, fail_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog: stop a hung run
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d levels outstanding", pending_levels.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
